FILE: hw/rtl/irr_pkg.sv
// Shared types and constants for the input-recording replay block.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package irr_pkg;

	// Block store geometry.
	localparam int MEM_BYTES  = 1048576;
	localparam int MEM_ADDR_W = $clog2(MEM_BYTES);

	// Field and register widths.
	localparam int PTR_W      = 22;
	localparam int CNT_W      = 16;
	localparam int FRAMES_W   = 32;
	localparam int BLEN_W     = 21;
	localparam int LADDR_W    = 20;
	localparam int BYTE_W     = 8;
	localparam int FAULT_W    = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 16;

	// Width used for address range compares; covers the largest store.
	localparam int CMP_W = 25;
	localparam logic [CMP_W-1:0] MEM_LIMIT = CMP_W'(MEM_BYTES);

	// A read count of all ones repeats the data of the last real frame.
	localparam logic [CNT_W-1:0] REPEAT_COUNT = 16'hFFFF;
	localparam logic [PTR_W-1:0] HDR_BYTES    = PTR_W'(4);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TOTAL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 1'b1;

	// Fault codes.
	localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_EXHAUSTED = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_LENGTH    = 2'd2;

	// Item kinds.
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_ARM   = 2'd1,
		OP_FRAME = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic clear_result;
		logic store_wr;
		logic arm;
		logic restart;
		logic fetch_exhaust;
		logic fetch_bad;
		logic hdr_lo_rd;
		logic hdr_hi_rd;
		logic fetch_apply;
		logic data_rd;
		logic data_bad;
		logic data_take;
		logic out_load;
	} irr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_t  op;
		logic active;
		logic armed;
		logic load_in_range;
		logic exhausted;
		logic hdr_ok;
		logic frame_used;
		logic rp_ok;
	} irr_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/irr_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the block store of the replay block.
`default_nettype none

module irr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/irr_datapath.sv
// Datapath of the replay block: playback pointers, counters, configuration,
// result registers and the block store. Depends on irr_pkg and irr_ram.
`default_nettype none

module irr_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire irr_pkg::irr_cmd_t                 cmd,
	output irr_pkg::irr_status_t                   status,
	input  wire irr_pkg::op_t                      op,
	input  wire logic [irr_pkg::LADDR_W-1:0]       load_addr,
	input  wire logic [irr_pkg::BYTE_W-1:0]        load_data,
	input  wire logic                              cfg_we,
	input  wire logic [irr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [irr_pkg::CFG_DATA_W-1:0]    cfg_data,
	output logic      [irr_pkg::BYTE_W-1:0]        port_value,
	output logic                                   replayed,
	output logic                                   playing,
	output logic      [irr_pkg::FAULT_W-1:0]       fault
);

	import irr_pkg::*;

	// Configuration.
	logic [FRAMES_W-1:0]   frame_total_q;
	logic [BLEN_W-1:0]     block_length_q;

	// Playback state.
	logic [PTR_W-1:0]      next_frame_ptr_q;
	logic [PTR_W-1:0]      read_ptr_q;
	logic [PTR_W-1:0]      last_data_ptr_q;
	logic [CNT_W-1:0]      last_read_count_q;
	logic [CNT_W-1:0]      reads_this_frame_q;
	logic [CNT_W-1:0]      reads_done_q;
	logic [FRAMES_W-1:0]   frames_done_q;
	logic                  active_q;
	logic                  armed_q;

	// Latched item, header low byte and the result being built.
	op_t                   op_q;
	logic [LADDR_W-1:0]    addr_q;
	logic [BYTE_W-1:0]     data_q;
	logic [BYTE_W-1:0]     count_lo_q;
	logic [BYTE_W-1:0]     value_q;
	logic                  replayed_q;
	logic [FAULT_W-1:0]    fault_q;

	// Store access.
	logic                  ram_re;
	logic [MEM_ADDR_W-1:0] ram_raddr;
	logic [BYTE_W-1:0]     ram_rdata;

	// Header and data addresses and their range checks.
	logic [PTR_W:0]        hdr_end;
	logic [PTR_W-1:0]      hdr_lo_addr;
	logic [PTR_W-1:0]      hdr_hi_addr;
	logic [PTR_W-1:0]      data_start;
	logic [CNT_W-1:0]      hdr_count;
	logic [CMP_W-1:0]      blen_ext;

	assign blen_ext    = CMP_W'(block_length_q);
	assign hdr_end     = {1'b0, next_frame_ptr_q} + (PTR_W+1)'(3);
	assign hdr_lo_addr = next_frame_ptr_q + PTR_W'(2);
	assign hdr_hi_addr = next_frame_ptr_q + PTR_W'(3);
	assign data_start  = next_frame_ptr_q + HDR_BYTES;
	assign hdr_count   = {ram_rdata, count_lo_q};

	// Status towards the controller.
	always_comb begin
		status.op            = op_q;
		status.active        = active_q;
		status.armed         = armed_q;
		status.load_in_range = CMP_W'(addr_q) < MEM_LIMIT;
		status.exhausted     = frames_done_q >= frame_total_q;
		status.hdr_ok        = (CMP_W'(hdr_end) < blen_ext) && (CMP_W'(hdr_end) < MEM_LIMIT);
		status.frame_used    = reads_done_q >= reads_this_frame_q;
		status.rp_ok         = (CMP_W'(read_ptr_q) < blen_ext)
			&& (CMP_W'(read_ptr_q) < MEM_LIMIT);
	end

	// One read port serves both header bytes and data bytes.
	assign ram_re = cmd.hdr_lo_rd | cmd.hdr_hi_rd | cmd.data_rd;
	always_comb begin
		priority if (cmd.hdr_lo_rd) begin
			ram_raddr = MEM_ADDR_W'(hdr_lo_addr);
		end else if (cmd.hdr_hi_rd) begin
			ram_raddr = MEM_ADDR_W'(hdr_hi_addr);
		end else begin
			ram_raddr = MEM_ADDR_W'(read_ptr_q);
		end
	end

	irr_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MEM_BYTES)
	) u_store (
		.clk  (clk),
		.we   (cmd.store_wr),
		.waddr(MEM_ADDR_W'(addr_q)),
		.wdata(data_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q  <= '0;
			block_length_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_FRAME_TOTAL) begin
				frame_total_q <= cfg_data;
			end else begin
				block_length_q <= cfg_data[BLEN_W-1:0];
			end
		end
	end

	// Playback pointers, counters and flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_frame_ptr_q   <= '0;
			read_ptr_q         <= '0;
			last_data_ptr_q    <= '0;
			last_read_count_q  <= '0;
			reads_this_frame_q <= '0;
			reads_done_q       <= '0;
			frames_done_q      <= '0;
			active_q           <= 1'b0;
			armed_q            <= 1'b0;
		end else begin
			if (cmd.arm) begin
				armed_q      <= 1'b1;
				active_q     <= 1'b1;
				reads_done_q <= '0;
			end
			if (cmd.restart) begin
				armed_q          <= 1'b0;
				frames_done_q    <= '0;
				next_frame_ptr_q <= '0;
			end
			if (cmd.fetch_exhaust || cmd.fetch_bad) begin
				active_q <= 1'b0;
			end
			// A fetched header either opens new data or repeats the last data run.
			if (cmd.fetch_apply) begin
				if (hdr_count == REPEAT_COUNT) begin
					read_ptr_q         <= last_data_ptr_q;
					reads_this_frame_q <= last_read_count_q;
					next_frame_ptr_q   <= data_start;
				end else begin
					read_ptr_q         <= data_start;
					last_data_ptr_q    <= data_start;
					last_read_count_q  <= hdr_count;
					reads_this_frame_q <= hdr_count;
					next_frame_ptr_q   <= data_start + PTR_W'(hdr_count);
				end
				reads_done_q  <= '0;
				frames_done_q <= frames_done_q + FRAMES_W'(1);
			end
			if (cmd.data_bad) begin
				active_q <= 1'b0;
			end
			if (cmd.data_bad || cmd.data_take) begin
				read_ptr_q   <= read_ptr_q + PTR_W'(1);
				reads_done_q <= reads_done_q + CNT_W'(1);
			end
		end
	end

	// Item latch and result registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op;
			addr_q <= load_addr;
			data_q <= load_data;
		end
		if (cmd.hdr_hi_rd) begin
			count_lo_q <= ram_rdata;
		end
		if (cmd.clear_result) begin
			value_q    <= '0;
			replayed_q <= 1'b0;
			fault_q    <= FAULT_NONE;
		end
		if (cmd.fetch_exhaust) begin
			fault_q <= FAULT_EXHAUSTED;
		end
		if (cmd.fetch_bad || cmd.data_bad) begin
			fault_q <= FAULT_LENGTH;
		end
		if (cmd.fetch_apply) begin
			fault_q <= FAULT_NONE;
		end
		if (cmd.data_rd || cmd.data_bad) begin
			replayed_q <= 1'b1;
		end
		if (cmd.data_take) begin
			value_q <= ram_rdata;
		end
		if (cmd.out_load) begin
			port_value <= value_q;
			replayed   <= replayed_q;
			playing    <= active_q;
			fault      <= fault_q;
		end
	end

`ifndef NO_ASSERTIONS
	// Arming always raises playback, and only a port read drops the arm.
	a_armed_active: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |-> active_q)
		else $error("armed without active playback");

	// Only a port read can hand out a replayed word.
	a_replay_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && replayed_q) |-> (op_q == OP_READ))
		else $error("replayed word for an item that is not a port read");

	// A successful header fetch leaves the frame count one higher.
	a_frame_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fetch_apply |=> (frames_done_q == $past(frames_done_q) + FRAMES_W'(1)))
		else $error("frame count did not advance on a fetch");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/irr_ctrl.sv
// Controller of the replay block: sequences item decode, frame fetches and
// data reads, and owns the output valid flag. Depends on irr_pkg.
`default_nettype none

module irr_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	input  wire irr_pkg::irr_status_t status,
	output irr_pkg::irr_cmd_t         cmd
);

	import irr_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_FETCH_CHK,
		ST_FETCH_LO,
		ST_FETCH_HI,
		ST_LOOP_CHK,
		ST_DATA_RD,
		ST_DATA_WAIT,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_fetch;
	logic   m_valid_q;

	assign m_tvalid = m_valid_q;
	assign s_tready = (state_q == ST_IDLE);

	// A frame item fetches once; a port read goes back to look for reads left.
	assign after_fetch = (status.op == OP_FRAME) ? ST_FINISH : ST_LOOP_CHK;

	// Next state and datapath commands.
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.latch = s_tvalid;
				if (s_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.clear_result = 1'b1;
				state_d          = ST_FINISH;
				unique case (status.op)
					OP_LOAD: begin
						cmd.store_wr = status.load_in_range;
					end
					OP_ARM: begin
						cmd.arm = 1'b1;
					end
					OP_FRAME: begin
						if (status.active && !status.armed) begin
							state_d = ST_FETCH_CHK;
						end
					end
					OP_READ: begin
						if (status.active && status.armed) begin
							cmd.restart = 1'b1;
							state_d     = ST_FETCH_CHK;
						end else if (status.active) begin
							state_d = ST_LOOP_CHK;
						end
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_FETCH_CHK: begin
				priority if (status.exhausted) begin
					cmd.fetch_exhaust = 1'b1;
					state_d           = after_fetch;
				end else if (!status.hdr_ok) begin
					cmd.fetch_bad = 1'b1;
					state_d       = after_fetch;
				end else begin
					cmd.hdr_lo_rd = 1'b1;
					state_d       = ST_FETCH_LO;
				end
			end
			ST_FETCH_LO: begin
				cmd.hdr_hi_rd = 1'b1;
				state_d       = ST_FETCH_HI;
			end
			ST_FETCH_HI: begin
				cmd.fetch_apply = 1'b1;
				state_d         = after_fetch;
			end
			ST_LOOP_CHK: begin
				priority if (!status.active) begin
					state_d = ST_FINISH;
				end else if (status.frame_used) begin
					state_d = ST_FETCH_CHK;
				end else begin
					state_d = ST_DATA_RD;
				end
			end
			ST_DATA_RD: begin
				if (status.rp_ok) begin
					cmd.data_rd = 1'b1;
					state_d     = ST_DATA_WAIT;
				end else begin
					cmd.data_bad = 1'b1;
					state_d      = ST_FINISH;
				end
			end
			ST_DATA_WAIT: begin
				cmd.data_take = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_FINISH: begin
				if (!m_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	// The output register is only refilled once its word has gone.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_valid_q || m_tready))
		else $error("output word overwritten before it was taken");

	// The high header byte is always read right after the low one.
	a_hdr_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH_HI) |-> ($past(state_q) == ST_FETCH_LO))
		else $error("header high byte taken out of order");

	// Exactly one word leaves the finish state per item.
	a_finish_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle after a word");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/input_recording_replay_top.sv
// Top level of the input-recording replay block.
// Depends on irr_pkg, irr_ctrl, irr_datapath and irr_ram.
//
// Usage: words enter on the slave stream (s_tvalid, s_tready, s_tdata,
// s_tuser) and every word gives exactly one word on the master stream
// (m_tvalid, m_tready, m_tdata, m_tuser). s_tuser carries the item kind:
// load a store byte, arm playback, frame boundary or port read. Frame
// total and block length are written through cfg_we, cfg_index and
// cfg_data while the block is idle.
// Sequence: a load or arm word is decoded and finished; a port read whose
// frame still has reads reads and takes a data byte; a frame word fetches
// a header, or finishes at once when ignored. The read after arming
// fetches a header first, and further headers are fetched on the way as
// frames run out. A fetch that ends playback skips the header reads, and
// a read ended that way skips its data reads. All header and data bytes
// pass in turn through the single read port of the block store.
// Reset clears playback state and configuration; the store contents are
// undefined until loaded. A stalled receiver holds the result in the
// output register; the next word is still accepted and worked on, and
// waits only when its own result is ready.
`default_nettype none

module input_recording_replay_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// s_tdata: load_addr [19:0], load_data [27:20], zero [31:28]
	input  wire logic [irr_pkg::IN_DATA_W-1:0]      s_tdata,
	// s_tuser: op [1:0]
	input  wire logic [1:0]                         s_tuser,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// m_tdata: port_value [7:0], playing [8], fault [10:9], zero [15:11]
	output logic      [irr_pkg::OUT_DATA_W-1:0]     m_tdata,
	// m_tuser: replayed [0]
	output logic                                    m_tuser,
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	input  wire logic                               cfg_we,
	input  wire logic [irr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [irr_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import irr_pkg::*;

	irr_cmd_t            cmd;
	irr_status_t         status;
	logic [BYTE_W-1:0]   port_value;
	logic                playing;
	logic [FAULT_W-1:0]  fault;

	irr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.status  (status),
		.cmd     (cmd)
	);

	irr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.op        (op_t'(s_tuser)),
		.load_addr (s_tdata[LADDR_W-1:0]),
		.load_data (s_tdata[LADDR_W+BYTE_W-1:LADDR_W]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.port_value(port_value),
		.replayed  (m_tuser),
		.playing   (playing),
		.fault     (fault)
	);

	// Pack the result word.
	assign m_tdata = {(OUT_DATA_W-BYTE_W-1-FAULT_W)'(0), fault, playing, port_value};

endmodule

`default_nettype wire
